[rtl/core/cpe_pkg.sv]
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types and constants for the complex polynomial evaluator.
// ----------------------------------------------------------------------------
package cpe_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int MUL_CHUNK_W    = 32;
    localparam int STEP_W         = 2;
    localparam int ADDR_W         = 3;
    localparam int PDATA_W        = 32;

    localparam logic REG_POINT_REAL = 1'b0;
    localparam logic REG_POINT_IMAG = 1'b1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] coeff_real;
        logic signed [FIELD_W-1:0] coeff_imag;
        logic                      last_coeff;
    } cpe_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value_real;
        logic signed [FIELD_W-1:0] value_imag;
    } cpe_out_t;

    typedef struct packed {
        logic              load_in;
        logic              mul_en;
        logic              mul_first;
        logic [STEP_W-1:0] mul_step;
        logic              sel_term;
        logic              upd_power;
        logic              upd_acc;
        logic              load_out;
    } cpe_cmd_t;

endpackage

[rtl/core/cpe_datapath.sv]
// ----------------------------------------------------------------------------
// cpe_datapath
// Running power, accumulator, four shared product lanes and result register.
// ----------------------------------------------------------------------------
module cpe_datapath #(
    parameter int DATA_WIDTH = cpe_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cpe_pkg::cpe_cmd_t                     cmd,
    input  cpe_pkg::cpe_in_t                      in_data,
    input  logic signed [cpe_pkg::FIELD_W-1:0]    point_real,
    input  logic signed [cpe_pkg::FIELD_W-1:0]    point_imag,
    output cpe_pkg::cpe_out_t                     out_data
);
    import cpe_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int CW = (DW > MUL_CHUNK_W) ? MUL_CHUNK_W : DW;

    // low DW bits of a*b, one chunk pair per step
    function automatic logic [DW-1:0] pp_term(input logic [DW-1:0] a,
                                              input logic [DW-1:0] b,
                                              input logic [STEP_W-1:0] step);
        logic [2*CW-1:0] ap;
        logic [2*CW-1:0] bp;
        logic [CW-1:0]   ac;
        logic [CW-1:0]   bc;
        logic [2*CW-1:0] p;
        ap = (2*CW)'(a);
        bp = (2*CW)'(b);
        ac = (step == STEP_W'(2)) ? ap[2*CW-1:CW] : ap[CW-1:0];
        bc = (step == STEP_W'(1)) ? bp[2*CW-1:CW] : bp[CW-1:0];
        p  = (2*CW)'(ac) * (2*CW)'(bc);
        if (step == STEP_W'(0)) begin
            return DW'(p);
        end else begin
            return DW'({p, {CW{1'b0}}});
        end
    endfunction

    logic [DW-1:0] power_r_reg, power_i_reg;
    logic [DW-1:0] acc_r_reg, acc_i_reg;
    logic [DW-1:0] coeff_r_reg, coeff_i_reg;
    logic [DW-1:0] lane_reg [0:3];
    logic [DW-1:0] term [0:3];
    logic [DW-1:0] pt_r, pt_i, b_r, b_i;
    cpe_out_t      out_reg;

    assign pt_r = DW'(point_real);
    assign pt_i = DW'(point_imag);
    assign b_r  = cmd.sel_term ? coeff_r_reg : pt_r;
    assign b_i  = cmd.sel_term ? coeff_i_reg : pt_i;

    always_comb begin
        term[0] = pp_term(power_r_reg, b_r, cmd.mul_step);
        term[1] = pp_term(power_i_reg, b_i, cmd.mul_step);
        term[2] = pp_term(power_r_reg, b_i, cmd.mul_step);
        term[3] = pp_term(power_i_reg, b_r, cmd.mul_step);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            coeff_r_reg <= DW'(in_data.coeff_real);
            coeff_i_reg <= DW'(in_data.coeff_imag);
        end
        if (cmd.mul_en) begin
            for (int k = 0; k < 4; k++) begin
                lane_reg[k] <= (cmd.mul_first ? '0 : lane_reg[k]) + term[k];
            end
        end
        if (cmd.load_out) begin
            out_reg.value_real <= FIELD_W'(acc_r_reg);
            out_reg.value_imag <= FIELD_W'(acc_i_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_r_reg <= DW'(1);
            power_i_reg <= '0;
            acc_r_reg   <= '0;
            acc_i_reg   <= '0;
        end else if (cmd.load_out) begin
            power_r_reg <= DW'(1);
            power_i_reg <= '0;
            acc_r_reg   <= '0;
            acc_i_reg   <= '0;
        end else begin
            if (cmd.upd_power) begin
                power_r_reg <= lane_reg[0] - lane_reg[1];
                power_i_reg <= lane_reg[2] + lane_reg[3];
            end
            if (cmd.upd_acc) begin
                acc_r_reg <= acc_r_reg + lane_reg[0] - lane_reg[1];
                acc_i_reg <= acc_i_reg + lane_reg[2] + lane_reg[3];
            end
        end
    end

    assign out_data = out_reg;

endmodule

[rtl/core/cpe_ctrl.sv]
// ----------------------------------------------------------------------------
// cpe_ctrl
// Sequencer: power update, term product, accumulate, result hand-off.
// ----------------------------------------------------------------------------
module cpe_ctrl #(
    parameter int DATA_WIDTH = cpe_pkg::DATA_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output cpe_pkg::cpe_cmd_t  cmd
);
    import cpe_pkg::*;

    // partial products per real product
    localparam int NPP = (DATA_WIDTH > MUL_CHUNK_W) ? 3 : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NPP - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_P,
        S_CMB_P,
        S_MUL_T,
        S_CMB_T,
        S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_reg, last_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_in   = 1'b1;
                    cmd.mul_en    = 1'b1;
                    cmd.mul_first = 1'b1;
                    last_next     = s_last;
                    step_next     = STEP_W'(1);
                    state_next    = (NPP > 1) ? S_MUL_P : S_CMB_P;
                end
            end
            S_MUL_P: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = step_reg;
                if (step_reg == STEP_LAST) begin
                    step_next  = '0;
                    state_next = S_CMB_P;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_CMB_P: begin
                cmd.upd_power = 1'b1;
                step_next     = '0;
                state_next    = S_MUL_T;
            end
            S_MUL_T: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_first = (step_reg == '0);
                cmd.mul_step  = step_reg;
                cmd.sel_term  = 1'b1;
                if (step_reg == STEP_LAST) begin
                    step_next  = '0;
                    state_next = S_CMB_T;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_CMB_T: begin
                cmd.upd_acc = 1'b1;
                state_next  = last_reg ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/core/complex_polynomial_evaluator.sv]
// ----------------------------------------------------------------------------
// complex_polynomial_evaluator
// Evaluates c1*x + c2*x^2 + ... + cn*x^n at a complex point x set over APB.
//
// Usage:
//   - Write point_real (0x0) and point_imag (0x4) over APB while idle.
//   - Send coefficients on s_* lowest power first, one request each;
//     last_coeff marks the highest power and closes the polynomial.
//   - One result per polynomial appears on m_* (value_real/value_imag).
// Sequence:
//   - Each coefficient is taken only from idle and runs to completion:
//     two dependent complex multiplies share four product lanes, and above
//     32 bits every product takes three partial-product steps.
//   - The last coefficient then passes a hand-off state that moves the sum
//     into the output register; m_valid rises with that load.
// Reset and stall:
//   - Reset clears x to 0, the power to 1 and the sum to 0.
//   - A held result does not block new coefficients; only a second finished
//     polynomial waits in the hand-off state until m_ready frees the output.
// ----------------------------------------------------------------------------
module complex_polynomial_evaluator #(
    parameter int DATA_WIDTH = cpe_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cpe_pkg::cpe_in_t               s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cpe_pkg::cpe_out_t              m_payload,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpe_pkg::ADDR_W-1:0]     paddr,
    input  logic [cpe_pkg::PDATA_W-1:0]    pwdata,
    output logic [cpe_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import cpe_pkg::*;

    logic signed [FIELD_W-1:0] point_real_reg;
    logic signed [FIELD_W-1:0] point_imag_reg;
    logic                      reg_sel;
    logic                      wr_en;
    cpe_cmd_t                  cmd;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_real_reg <= '0;
            point_imag_reg <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_POINT_REAL: point_real_reg <= FIELD_W'(pwdata);
                REG_POINT_IMAG: point_imag_reg <= FIELD_W'(pwdata);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_POINT_REAL: prdata = PDATA_W'(point_real_reg);
            REG_POINT_IMAG: prdata = PDATA_W'(point_imag_reg);
            default:        prdata = '0;
        endcase
    end

    cpe_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_payload.last_coeff),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    cpe_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_data    (s_payload),
        .point_real (point_real_reg),
        .point_imag (point_imag_reg),
        .out_data   (m_payload)
    );

endmodule

[sim/complex_polynomial_evaluator_tb.sv]
// ----------------------------------------------------------------------------
// complex_polynomial_evaluator_tb
// Checks that the complex polynomial evaluator returns the right value.
// Coefficients go in as valid/ready requests, with random gaps on both
// channels. The point x is set over APB while the block is idle. A model of
// the power and sum inside the bench computes each value, wrapped to
// 32 bits, and the checker compares every result with it.
// ----------------------------------------------------------------------------
module complex_polynomial_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpe_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int IDLE_SETTLE  = 16;
    localparam logic [31:0] MAX_S = 32'h7fff_ffff;
    localparam logic [31:0] MIN_S = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
    } cplx_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    cpe_in_t             s_payload;
    logic                m_valid;
    logic                m_ready;
    cpe_out_t            m_payload;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // model of the block
    cplx_t    point_x;
    cplx_t    run_power;
    cplx_t    run_sum;
    cpe_out_t poly_values_q[$];

    int  err_count;
    int  cycle_count;
    int  ready_stall;
    bit  no_gaps;

    complex_polynomial_evaluator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic cplx_t cx_mul(cplx_t a, cplx_t b);
        cplx_t r;
        r.re = a.re * b.re - a.im * b.im;
        r.im = a.re * b.im + a.im * b.re;
        return r;
    endfunction

    function automatic void fold_coeff(cpe_in_t item);
        cplx_t    c;
        cplx_t    term;
        cpe_out_t val;
        c.re      = item.coeff_real;
        c.im      = item.coeff_imag;
        run_power = cx_mul(run_power, point_x);
        term      = cx_mul(run_power, c);
        run_sum.re = run_sum.re + term.re;
        run_sum.im = run_sum.im + term.im;
        if (item.last_coeff) begin
            val.value_real = run_sum.re;
            val.value_imag = run_sum.im;
            poly_values_q.push_back(val);
            run_power = '{re: 32'd1, im: 32'd0};
            run_sum   = '0;
        end
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return MAX_S;
        if (r < 16)
            return MIN_S;
        if (r < 20)
            return 32'd0;
        if (r < 25)
            return 32'hffff_ffff;
        if (r < 40)
            return 32'($signed($urandom_range(0, 30)) - 15);
        return $urandom;
    endfunction

    function automatic int pick_poly_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 4);
        if (r < 95)
            return $urandom_range(5, 10);
        return $urandom_range(11, 24);
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Entered and left at a falling edge; valid stays high after acceptance.
    task automatic send_coeff(logic [31:0] re, logic [31:0] im, logic last);
        int      gap;
        cpe_in_t item;
        gap = pick_gap();
        item.coeff_real = re;
        item.coeff_imag = im;
        item.last_coeff = last;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_payload = item;
        s_valid   = 1'b1;
        do @(posedge aclk); while (!s_ready);
        fold_coeff(item);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (poly_values_q.size() != 0)
            @(negedge aclk);
        repeat (IDLE_SETTLE) @(negedge aclk);
    endtask

    task automatic write_point_reg(logic idx, logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_POINT_REAL)
            point_x.re = value;
        else
            point_x.im = value;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_point(logic [31:0] re, logic [31:0] im);
        write_point_reg(REG_POINT_REAL, re);
        write_point_reg(REG_POINT_IMAG, im);
    endtask

    // result checker
    always @(posedge aclk) begin
        cpe_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (poly_values_q.size() == 0) begin
                report_error($sformatf("unexpected result %h_%h",
                                       m_payload.value_real, m_payload.value_imag));
            end else begin
                want = poly_values_q.pop_front();
                if (m_payload.value_real !== want.value_real)
                    report_error($sformatf("value_real got %h expected %h",
                                           m_payload.value_real, want.value_real));
                if (m_payload.value_imag !== want.value_imag)
                    report_error($sformatf("value_imag got %h expected %h",
                                           m_payload.value_imag, want.value_imag));
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            m_ready = 1'b0;
            ready_stall--;
        end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
            m_ready     = 1'b0;
            ready_stall = pick_gap();
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // x is zero out of reset, so every value is zero
    task automatic test_reset_state();
        send_coeff(32'd5, 32'd7, 1'b1);
        send_coeff(MAX_S, MIN_S, 1'b0);
        send_coeff(32'hffff_ffff, 32'd1, 1'b1);
        wait_idle();
    endtask

    task automatic test_directed_polys();
        set_point(32'd2, 32'd3);
        send_coeff(32'd1, 32'd0, 1'b0);
        send_coeff(32'd0, 32'd1, 1'b0);
        send_coeff(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        // power must restart at 1 right after a result
        send_coeff(32'd7, 32'hffff_fff9, 1'b1);
        wait_idle();
        // wraparound
        set_point(MAX_S, MIN_S);
        send_coeff(MAX_S, MIN_S, 1'b0);
        send_coeff(MIN_S, MAX_S, 1'b0);
        send_coeff(32'hffff_ffff, 32'd0, 1'b1);
        send_coeff(32'd0, 32'd0, 1'b1);
        wait_idle();
        set_point(MIN_S, MIN_S);
        send_coeff(MAX_S, MAX_S, 1'b1);
        wait_idle();
        set_point(32'hffff_ffff, 32'hffff_ffff);
        repeat (3) send_coeff(32'd1, 32'd1, 1'b0);
        send_coeff(32'd1, 32'd1, 1'b1);
        wait_idle();
    endtask

    task automatic test_point_change_mid_poly();
        set_point(32'd1, 32'd1);
        send_coeff(32'd3, 32'd4, 1'b0);
        send_coeff(32'd5, 32'd6, 1'b0);
        wait_idle();
        set_point(32'hffff_ffff, 32'd0);
        send_coeff(32'd7, 32'd8, 1'b0);
        send_coeff(32'd9, 32'hffff_fff6, 1'b1);
        wait_idle();
    endtask

    // open polynomials carry over phase boundaries, so x also changes mid-way
    task automatic test_random_polys();
        int   poly_left;
        logic last;
        poly_left = 0;
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            set_point(rand_word(), rand_word());
            no_gaps = (phase % 3 == 2);
            for (int i = 0; i < 94; i++) begin
                if (poly_left == 0)
                    poly_left = pick_poly_len();
                poly_left--;
                last = (poly_left == 0) || (phase == 7 && i == 93);
                if (last)
                    poly_left = 0;
                send_coeff(rand_word(), rand_word(), last);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_payload   = '0;
        m_ready     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        err_count   = 0;
        cycle_count = 0;
        ready_stall = 0;
        no_gaps     = 1'b0;
        point_x     = '0;
        run_power   = '{re: 32'd1, im: 32'd0};
        run_sum     = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_directed_polys();
        test_point_change_mid_poly();
        test_random_polys();

        wait_idle();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
